// ===== rtl/mte_pkg.sv =====
// Package for the multi-tap text entry editor.
// Holds the key table, letter groups, store entry type and the microprogram ROM.
// No dependencies.
`default_nettype none

package mte_pkg;

  localparam int unsigned KeyW    = 16;
  localparam int unsigned ActW    = 3;
  localparam int unsigned LetterW = 8;
  localparam int unsigned ColW    = 7;
  localparam int unsigned RowW    = 8;
  localparam int unsigned PrevW   = KeyW + 1;
  localparam int unsigned KidxW   = 4;
  localparam int unsigned UpcW    = 4;

  localparam logic [KeyW-1:0]    KeyMute  = 16'h708F;
  localparam logic [KeyW-1:0]    KeyLast  = 16'h08F7;
  localparam logic [PrevW-1:0]   NoPrev   = 17'h10000;
  localparam logic [ColW-1:0]    ColHome  = 7'd5;
  localparam logic [RowW-1:0]    RowHome  = 8'd68;
  localparam logic [ColW-1:0]    ColStep  = 7'd7;
  localparam logic [ColW-1:0]    ColWrap  = 7'd124;
  localparam logic [ColW-1:0]    ColBack  = 7'd12;
  localparam logic [ColW-1:0]    ColEnd   = 7'd117;
  localparam logic [RowW-1:0]    RowStep  = 8'd10;
  localparam logic [RowW-1:0]    RowBack  = 8'd78;
  localparam logic [RowW-1:0]    RowSat   = 8'd245;
  localparam logic [RowW-1:0]    RowMax   = 8'd255;
  localparam logic [LetterW-1:0] ChSlash  = 8'h2F;
  localparam logic [LetterW-1:0] ChQuery  = 8'h3F;
  localparam logic [LetterW-1:0] ChDot    = 8'h2E;
  localparam logic [LetterW-1:0] ChComma  = 8'h2C;

  localparam logic [KidxW-1:0] KidxSpace = 4'd0;
  localparam logic [KidxW-1:0] KidxPunct = 4'd1;
  localparam logic [KidxW-1:0] KidxNone  = 4'd15;

  typedef enum logic {
    OP_KEY     = 1'b0,
    OP_TIMEOUT = 1'b1
  } opcode_e;

  typedef enum logic [ActW-1:0] {
    ACT_NEW     = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_ERASE   = 3'd2,
    ACT_SEND    = 3'd3,
    ACT_TERM    = 3'd4
  } action_e;

  typedef enum logic [UpcW-1:0] {
    U_IDLE   = 4'd0,
    U_M_RD   = 4'd1,
    U_M_EMIT = 4'd2,
    U_M_CUR  = 4'd3,
    U_S_RD   = 4'd4,
    U_S_EMIT = 4'd5,
    U_S_TERM = 4'd6,
    U_R_RD   = 4'd7,
    U_R_EMIT = 4'd8,
    U_A_EMIT = 4'd9
  } upc_e;

  typedef enum logic { RS_LAST = 1'b0, RS_IDX = 1'b1 } rd_sel_e;
  typedef enum logic [1:0] { CNT_KEEP, CNT_DEC, CNT_INC, CNT_CLR } cnt_op_e;
  typedef enum logic [1:0] { CUR_KEEP, CUR_BACK, CUR_ADV, CUR_HOME } cur_op_e;
  typedef enum logic [1:0] { J_NEXT, J_DISPATCH, J_LOOP, J_GOTO } jmp_e;

  typedef struct packed {
    logic                 rdy_in;
    logic                 rd_en;
    rd_sel_e              rd_sel;
    logic                 emit;
    action_e              act;
    logic                 is_last;
    cnt_op_e              cnt_op;
    cur_op_e              cur_op;
    logic                 idx_inc;
    jmp_e                 jmp;
    upc_e                 tgt;
  } ucw_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic more;
    upc_e disp;
  } seq_stat_t;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic [ColW-1:0]    col;
    logic [RowW-1:0]    row;
  } entry_t;

  function automatic logic [KeyW-1:0] key_code_of(input logic [KidxW-1:0] idx);
    logic [KeyW-1:0] c;
    case (idx)
      4'd0:    c = 16'h906F;
      4'd1:    c = 16'h00FF;
      4'd2:    c = 16'h807F;
      4'd3:    c = 16'h40BF;
      4'd4:    c = 16'hC03F;
      4'd5:    c = 16'h20DF;
      4'd6:    c = 16'hA05F;
      4'd7:    c = 16'h609F;
      4'd8:    c = 16'hE01F;
      4'd9:    c = 16'h10EF;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [KidxW-1:0] key_index(input logic [KeyW-1:0] code);
    logic [KidxW-1:0] r;
    r = KidxNone;
    for (int i = 9; i >= 0; i--) begin
      if (code == key_code_of(KidxW'(i))) r = KidxW'(i);
    end
    return r;
  endfunction

  function automatic logic [LetterW-1:0] group_first(input logic [KidxW-1:0] idx);
    logic [LetterW-1:0] c;
    case (idx)
      4'd0:    c = 8'h20;
      4'd1:    c = 8'h3F;
      4'd2:    c = 8'h61;
      4'd3:    c = 8'h64;
      4'd4:    c = 8'h67;
      4'd5:    c = 8'h6A;
      4'd6:    c = 8'h6D;
      4'd7:    c = 8'h70;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h77;
      default: c = ChSlash;
    endcase
    return c;
  endfunction

  function automatic logic [LetterW-1:0] group_last(input logic [KidxW-1:0] idx);
    logic [LetterW-1:0] c;
    case (idx)
      4'd0:    c = 8'h20;
      4'd1:    c = 8'h3F;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h66;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h6C;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h76;
      4'd9:    c = 8'h7A;
      default: c = ChSlash;
    endcase
    return c;
  endfunction

  function automatic logic [LetterW-1:0] next_letter(input logic [LetterW-1:0] cur,
                                                     input logic [KidxW-1:0] idx);
    logic [LetterW-1:0] n;
    if (idx == KidxPunct) begin
      if (cur == ChQuery)      n = ChDot;
      else if (cur == ChDot)   n = ChComma;
      else                     n = ChQuery;
    end else if (idx == KidxSpace || idx > 4'd9) begin
      n = cur;
    end else if (cur == group_last(idx)) begin
      n = group_first(idx);
    end else begin
      n = cur + 8'd1;
    end
    return n;
  endfunction

  function automatic ucw_t ucode(input upc_e upc);
    ucw_t w;
    w = '{rdy_in: 1'b0, rd_en: 1'b0, rd_sel: RS_LAST, emit: 1'b0, act: ACT_NEW,
          is_last: 1'b0, cnt_op: CNT_KEEP, cur_op: CUR_KEEP, idx_inc: 1'b0,
          jmp: J_GOTO, tgt: U_IDLE};
    case (upc)
      U_IDLE: begin
        w.rdy_in = 1'b1;
        w.jmp    = J_DISPATCH;
      end
      U_M_RD: begin
        w.rd_en  = 1'b1;
        w.cnt_op = CNT_DEC;
        w.jmp    = J_NEXT;
      end
      U_M_EMIT: begin
        w.emit    = 1'b1;
        w.act     = ACT_ERASE;
        w.is_last = 1'b1;
        w.jmp     = J_NEXT;
      end
      U_M_CUR: begin
        w.cur_op = CUR_BACK;
      end
      U_S_RD: begin
        w.rd_en  = 1'b1;
        w.rd_sel = RS_IDX;
        w.jmp    = J_NEXT;
      end
      U_S_EMIT: begin
        w.emit    = 1'b1;
        w.act     = ACT_SEND;
        w.idx_inc = 1'b1;
        w.jmp     = J_LOOP;
        w.tgt     = U_S_RD;
      end
      U_S_TERM: begin
        w.emit    = 1'b1;
        w.act     = ACT_TERM;
        w.is_last = 1'b1;
        w.cnt_op  = CNT_CLR;
        w.cur_op  = CUR_HOME;
      end
      U_R_RD: begin
        w.rd_en = 1'b1;
        w.jmp   = J_NEXT;
      end
      U_R_EMIT: begin
        w.emit    = 1'b1;
        w.act     = ACT_REPLACE;
        w.is_last = 1'b1;
      end
      U_A_EMIT: begin
        w.emit    = 1'b1;
        w.act     = ACT_NEW;
        w.is_last = 1'b1;
        w.cnt_op  = CNT_INC;
        w.cur_op  = CUR_ADV;
      end
      default: begin
        w.jmp = J_GOTO;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mte_in_if.sv =====
// Input channel of the editor: key code or timeout beats.
// Depends on mte_pkg.
`default_nettype none

interface mte_in_if
  import mte_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [KeyW-1:0] key_code;

  modport source (output valid, output opcode, output key_code, input ready);
  modport sink   (input valid, input opcode, input key_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/mte_out_if.sv =====
// Output channel of the editor: draw, erase and send beats.
// Depends on mte_pkg.
`default_nettype none

interface mte_out_if
  import mte_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ActW-1:0]    action;
  logic [LetterW-1:0] letter;
  logic [ColW-1:0]    pos_x;
  logic [RowW-1:0]    pos_y;
  logic               last;

  modport source (output valid, output action, output letter, output pos_x,
                  output pos_y, output last, input ready);
  modport sink   (input valid, input action, input letter, input pos_x,
                  input pos_y, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/mte_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/mte_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on mte_pkg.
`default_nettype none

module mte_seq
  import mte_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire seq_stat_t stat_i,
  output      ucw_t      ucw_o,
  output      logic      fire_o
);

  upc_e upc_q, upc_d;
  ucw_t ucw;
  logic fire;

  assign ucw  = ucode(upc_q);
  // an emitting step holds until the output register is free
  assign fire = !ucw.emit || stat_i.out_free;

  always_comb begin
    upc_d = upc_q;
    if (fire) begin
      case (ucw.jmp)
        J_NEXT:     upc_d = upc_e'(upc_q + 4'd1);
        J_DISPATCH: upc_d = stat_i.in_valid ? stat_i.disp : upc_q;
        J_LOOP:     upc_d = stat_i.more ? ucw.tgt : upc_e'(upc_q + 4'd1);
        J_GOTO:     upc_d = ucw.tgt;
        default:    upc_d = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ucw_o  = ucw;
  assign fire_o = fire;

endmodule

`default_nettype wire

// ===== rtl/multitap_text_entry_editor_core.sv =====
// Multi-tap text entry editor, top level: datapath, letter store and output register.
// Depends on mte_pkg, mte_in_if, mte_out_if, mte_ram and mte_seq.
//
// Usage: in_i carries one beat per decoded key code (opcode 0) or repeat
// timeout (opcode 1). out_o carries the resulting draw, replace, erase, send
// and terminator beats; last marks the final beat caused by an input beat.
// A timeout or an ignored key gives no beat.
// in_i.ready is high only while the sequencer sits in its idle step, so one
// input beat is worked on at a time.
// After acceptance a timeout or ignored key returns to idle; a new letter
// emits a draw; a replace reads, then emits; a mute reads, emits the erase
// and steps the cursor back (only the step if the store is empty); a send reads
// each letter with a registered RAM read and loads it, then the terminator.
// Each beat is registered in the cycle after the step that loads it.
// A stalled receiver holds the output register; the emitting step waits
// until it is taken. Reset empties the store, homes the cursor to column 5,
// row 68 and clears the previous code to 0. No clearing pass is needed.
`default_nettype none

module multitap_text_entry_editor_core
  import mte_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mte_in_if.sink    in_i,
  mte_out_if.source out_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  ucw_t      ucw;
  logic      fire;
  seq_stat_t stat;

  logic [CntW-1:0]    cnt_q, cnt_d, idx_q, idx_d, cnt_m1;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [PrevW-1:0]   prev_q, prev_d;
  logic [KidxW-1:0]   kidx_q;
  logic               out_valid_q;
  logic [ActW-1:0]    out_act_q;
  entry_t             out_ent_q;
  logic               out_last_q;

  logic               in_acc, out_free, step_emit;
  logic               is_mute, is_send, same;
  upc_e               disp;
  logic [ColW:0]      col_adv;
  logic               ram_we;
  logic [AddrW-1:0]   waddr, raddr;
  entry_t             wdata, rdata, emit_ent;
  logic [CntW:0]      idx_p1;

  mte_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ucw_o  (ucw),
    .fire_o (fire)
  );

  assign in_i.ready = ucw.rdy_in;
  assign in_acc     = in_i.valid && ucw.rdy_in;
  assign out_free   = !out_valid_q || out_o.ready;
  assign step_emit  = fire && ucw.emit;

  // dispatch decode of the incoming beat
  assign is_mute = (in_i.key_code == KeyMute);
  assign is_send = (in_i.key_code == KeyLast);
  assign same    = (prev_q == {1'b0, in_i.key_code});
  assign cnt_m1  = cnt_q - 1'b1;
  assign idx_p1  = {1'b0, idx_q} + 1'b1;

  always_comb begin
    if (in_i.opcode == OP_TIMEOUT) begin
      disp = U_IDLE;
    end else if (is_mute) begin
      disp = (cnt_q != '0) ? U_M_RD : U_M_CUR;
    end else if (is_send) begin
      disp = (cnt_q != '0) ? U_S_RD : U_IDLE;
    end else if (cnt_q < CapCnt) begin
      disp = (same && cnt_q != '0) ? U_R_RD : U_A_EMIT;
    end else begin
      disp = U_IDLE;
    end
  end

  assign stat = '{in_valid: in_i.valid, out_free: out_free,
                  more: (idx_p1 < {1'b0, cnt_q}), disp: disp};

  // letter store
  assign raddr = (ucw.rd_sel == RS_IDX) ? idx_q[AddrW-1:0] : cnt_m1[AddrW-1:0];

  always_comb begin
    ram_we = 1'b0;
    waddr  = cnt_q[AddrW-1:0];
    wdata  = '{letter: group_first(kidx_q), col: col_q, row: row_q};
    if (step_emit && ucw.act == ACT_NEW) begin
      ram_we = 1'b1;
    end else if (step_emit && ucw.act == ACT_REPLACE) begin
      ram_we = 1'b1;
      waddr  = cnt_m1[AddrW-1:0];
      wdata  = '{letter: next_letter(rdata.letter, kidx_q), col: rdata.col, row: rdata.row};
    end
  end

  mte_ram #(
    .Width ($bits(entry_t)),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ucw.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    case (ucw.act)
      ACT_NEW, ACT_REPLACE: emit_ent = wdata;
      ACT_TERM:             emit_ent = '0;
      default:              emit_ent = rdata;
    endcase
  end

  // counters and cursor
  assign col_adv = {1'b0, col_q} + {1'b0, ColStep};

  always_comb begin
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    col_d  = col_q;
    row_d  = row_q;
    prev_d = prev_q;
    if (in_acc) begin
      prev_d = (in_i.opcode == OP_TIMEOUT) ? NoPrev : {1'b0, in_i.key_code};
      idx_d  = '0;
    end
    if (fire) begin
      if (ucw.idx_inc) idx_d = idx_p1[CntW-1:0];
      case (ucw.cnt_op)
        CNT_DEC:  cnt_d = cnt_m1;
        CNT_INC:  cnt_d = cnt_q + 1'b1;
        CNT_CLR:  cnt_d = '0;
        default:  cnt_d = cnt_q;
      endcase
      case (ucw.cur_op)
        CUR_BACK: begin
          if (col_q >= ColBack) begin
            col_d = col_q - ColStep;
          end else if (col_q == ColHome && row_q >= RowBack) begin
            col_d = ColEnd;
            row_d = row_q - RowStep;
          end
        end
        CUR_ADV: begin
          if (col_adv >= {1'b0, ColWrap}) begin
            col_d = ColHome;
            row_d = (row_q >= RowSat) ? RowMax : row_q + RowStep;
          end else begin
            col_d = col_adv[ColW-1:0];
          end
        end
        CUR_HOME: begin
          col_d = ColHome;
          row_d = RowHome;
        end
        default: begin
          col_d = col_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      col_q       <= ColHome;
      row_q       <= RowHome;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      col_q  <= col_d;
      row_q  <= row_d;
      prev_q <= prev_d;
      if (step_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kidx_q <= key_index(in_i.key_code);
    end
    if (step_emit) begin
      out_act_q  <= ucw.act;
      out_ent_q  <= emit_ent;
      out_last_q <= ucw.is_last;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.action = out_act_q;
  assign out_o.letter = out_ent_q.letter;
  assign out_o.pos_x  = out_ent_q.col;
  assign out_o.pos_y  = out_ent_q.row;
  assign out_o.last   = out_last_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapCnt)
    else $error("letter count beyond capacity");

  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q >= ColHome && col_q <= ColEnd)
    else $error("cursor column out of range");

  a_timeout_forget : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == OP_TIMEOUT) |=> prev_q == NoPrev)
    else $error("timeout did not clear previous code");

  a_term_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_emit && ucw.act == ACT_TERM) |=> (cnt_q == '0 && out_o.valid))
    else $error("terminator beat left the store filled");

  a_no_load_over_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !step_emit)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
